[rtl/core/nsrg_pkg.sv]
// ----------------------------------------------------------------------------
// nsrg_pkg: shared types and constants of the natural selection run generator
// Default sizes, fixed field widths and the command and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package nsrg_pkg;

   // Default sizes, used as the defaults of the top level's parameters.
   localparam int MEMORY_ENTRIES_DEF = 8;
   localparam int KEY_BITS_DEF       = 32;

   // Fixed widths of the record and run fields.
   localparam int REC_BITS = 32;
   localparam int RUN_BITS = 16;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic insert;      // take in the accepted record
      logic emit;        // send the smallest valid entry to the output register
      logic set_free;    // the emitted slot becomes the free slot
      logic run_end;     // the emitted record closes its run
      logic burst_last;  // the emitted record is the last of its transaction
      logic swap;        // the reservoir becomes memory
      logic restart;     // clear the valid bits, counts, free slot and last key
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ins_full;      // the insert leaves memory full
      logic ins_flush;     // the insert fills the reservoir
      logic any_valid;     // memory holds at least one valid entry
      logic one_valid;     // memory holds exactly one valid entry
      logic res_nonempty;  // the reservoir holds at least one record
      logic out_free;      // the output register can take a result
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/core/nsrg_dp.sv]
// ----------------------------------------------------------------------------
// nsrg_dp: datapath of the natural selection run generator
// Two key banks that trade the memory and reservoir roles, valid bits, the
// counters, a minimum search tree over memory and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nsrg_dp #(
   parameter int MEMORY_ENTRIES = nsrg_pkg::MEMORY_ENTRIES_DEF,
   parameter int KEY_BITS       = nsrg_pkg::KEY_BITS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire logic signed [nsrg_pkg::REC_BITS-1:0] req_record_value,
   input  wire nsrg_pkg::dp_cmd_type            cmd,
   output nsrg_pkg::dp_status_type              status,
   output logic signed [nsrg_pkg::REC_BITS-1:0] rsp_out_value,
   output logic [nsrg_pkg::RUN_BITS-1:0]        rsp_run_index,
   output logic                                 rsp_run_end,
   output logic                                 rsp_burst_last,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready
);

   localparam int SLOT_BITS   = $clog2(MEMORY_ENTRIES);
   localparam int CNT_BITS    = $clog2(MEMORY_ENTRIES + 1);
   localparam int TREE_LEAVES = 1 << SLOT_BITS;
   localparam logic [CNT_BITS-1:0] M_CNT  = CNT_BITS'(MEMORY_ENTRIES);
   localparam logic [CNT_BITS-1:0] M_LAST = CNT_BITS'(MEMORY_ENTRIES - 1);

   // Work state.
   logic signed [KEY_BITS-1:0] key_ff [2][MEMORY_ENTRIES];
   logic [MEMORY_ENTRIES-1:0]  valid_ff, valid_in;
   logic                       bank_ff, bank_in;
   logic [CNT_BITS-1:0]        fill_ff, fill_in;
   logic [CNT_BITS-1:0]        rc_ff, rc_in;
   logic [SLOT_BITS-1:0]       free_ff, free_in;
   logic signed [KEY_BITS-1:0] last_ff, last_in;
   logic [nsrg_pkg::RUN_BITS-1:0] run_ff, run_in;

   // Output register.
   logic signed [nsrg_pkg::REC_BITS-1:0] out_value_ff;
   logic [nsrg_pkg::RUN_BITS-1:0]        out_run_ff;
   logic                                 out_run_end_ff;
   logic                                 out_burst_last_ff;
   logic                                 out_valid_ff, out_valid_in;

   logic signed [KEY_BITS-1:0]           rec_key;
   logic signed [nsrg_pkg::REC_BITS-1:0] min_value;
   logic                                 fill_open;
   logic                                 key_ge_last;
   logic                                 wr_mem;
   logic                                 wr_bank;
   logic [SLOT_BITS-1:0]                 wr_addr;

   // Minimum search tree, laid out as a heap with the leaves at the bottom.
   logic signed [KEY_BITS-1:0] node_key [1:2*TREE_LEAVES-1];
   logic [SLOT_BITS-1:0]       node_idx [1:2*TREE_LEAVES-1];
   logic                       node_ok  [1:2*TREE_LEAVES-1];

   // Key width conversion of the incoming record and the outgoing key.
   generate
      if (KEY_BITS <= nsrg_pkg::REC_BITS) begin : g_key_narrow
         assign rec_key = req_record_value[KEY_BITS-1:0];
      end else begin : g_key_wide
         assign rec_key = {{(KEY_BITS - nsrg_pkg::REC_BITS)
                            {req_record_value[nsrg_pkg::REC_BITS-1]}}, req_record_value};
      end
      if (KEY_BITS >= nsrg_pkg::REC_BITS) begin : g_out_narrow
         assign min_value = node_key[1][nsrg_pkg::REC_BITS-1:0];
      end else begin : g_out_wide
         assign min_value = {{(nsrg_pkg::REC_BITS - KEY_BITS){node_key[1][KEY_BITS-1]}},
                             node_key[1]};
      end
   endgenerate

   // Smallest valid entry; on equal keys the lower slot wins.
   always_comb begin
      logic take_left;
      take_left = 1'b0;
      for (int i = 0; i < TREE_LEAVES; i++) begin
         node_idx[TREE_LEAVES + i] = SLOT_BITS'(i);
         if (i < MEMORY_ENTRIES) begin
            node_ok[TREE_LEAVES + i]  = valid_ff[i];
            node_key[TREE_LEAVES + i] = key_ff[bank_ff][i];
         end else begin
            node_ok[TREE_LEAVES + i]  = 1'b0;
            node_key[TREE_LEAVES + i] = '0;
         end
      end
      for (int n = TREE_LEAVES - 1; n >= 1; n--) begin
         take_left = node_ok[2*n] &&
                     (!node_ok[2*n+1] || (node_key[2*n] <= node_key[2*n+1]));
         node_ok[n]  = node_ok[2*n] || node_ok[2*n+1];
         node_key[n] = take_left ? node_key[2*n] : node_key[2*n+1];
         node_idx[n] = take_left ? node_idx[2*n] : node_idx[2*n+1];
      end
   end

   // Placement of an incoming record.
   assign fill_open   = (fill_ff != M_CNT);
   assign key_ge_last = (rec_key >= last_ff);
   assign wr_mem      = fill_open || key_ge_last;
   assign wr_bank     = wr_mem ? bank_ff : !bank_ff;
   assign wr_addr     = fill_open ? fill_ff[SLOT_BITS-1:0] :
                        (key_ge_last ? free_ff : rc_ff[SLOT_BITS-1:0]);

   // Status towards the controller.
   always_comb begin
      status.ins_full     = fill_open ? (fill_ff == M_LAST) : key_ge_last;
      status.ins_flush    = !fill_open && !key_ge_last && (rc_ff == M_LAST);
      status.any_valid    = (valid_ff != '0);
      status.one_valid    = (valid_ff != '0) &&
                            ((valid_ff & (valid_ff - MEMORY_ENTRIES'(1))) == '0);
      status.res_nonempty = (rc_ff != '0);
      status.out_free     = !out_valid_ff || rsp_ready;
   end

   // Next work state; per field, restart overrides swap, which overrides emit.
   always_comb begin
      valid_in = valid_ff;
      bank_in  = bank_ff;
      fill_in  = fill_ff;
      rc_in    = rc_ff;
      free_in  = free_ff;
      last_in  = last_ff;
      run_in   = run_ff;
      if (cmd.insert) begin
         if (fill_open) begin
            fill_in = fill_ff + CNT_BITS'(1);
         end
         if (wr_mem) begin
            valid_in[wr_addr] = 1'b1;
         end else begin
            rc_in = rc_ff + CNT_BITS'(1);
         end
      end
      if (cmd.emit) begin
         valid_in[node_idx[1]] = 1'b0;
         last_in = node_key[1];
         if (cmd.set_free) begin
            free_in = node_idx[1];
         end
         if (cmd.run_end) begin
            run_in = run_ff + nsrg_pkg::RUN_BITS'(1);
         end
      end
      if (cmd.swap) begin
         bank_in = !bank_ff;
         rc_in   = '0;
         for (int i = 0; i < MEMORY_ENTRIES; i++) begin
            valid_in[i] = (CNT_BITS'(i) < rc_ff);
         end
      end
      if (cmd.restart) begin
         valid_in = '0;
         fill_in  = '0;
         rc_in    = '0;
         free_in  = '0;
         last_in  = '0;
      end
   end

   // Output register: loaded on an emission, cleared when taken.
   always_comb begin
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         bank_ff      <= 1'b0;
         fill_ff      <= '0;
         rc_ff        <= '0;
         free_ff      <= '0;
         last_ff      <= '0;
         run_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         bank_ff      <= bank_in;
         fill_ff      <= fill_in;
         rc_ff        <= rc_in;
         free_ff      <= free_in;
         last_ff      <= last_in;
         run_ff       <= run_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Key banks, written at one address per cycle.
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         key_ff[wr_bank][wr_addr] <= rec_key;
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_value_ff      <= min_value;
         out_run_ff        <= run_ff;
         out_run_end_ff    <= cmd.run_end;
         out_burst_last_ff <= cmd.burst_last;
      end
   end

   assign rsp_out_value  = out_value_ff;
   assign rsp_run_index  = out_run_ff;
   assign rsp_run_end    = out_run_end_ff;
   assign rsp_burst_last = out_burst_last_ff;
   assign rsp_valid      = out_valid_ff;

endmodule

`default_nettype wire

[rtl/core/nsrg_ctrl.sv]
// ----------------------------------------------------------------------------
// nsrg_ctrl: controller of the natural selection run generator
// Accepts one record at a time and sequences the single emission or the
// memory and reservoir flushes that it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module nsrg_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   input  wire                          req_end_of_input,
   output logic                         req_ready,
   input  wire nsrg_pkg::dp_status_type status,
   output nsrg_pkg::dp_cmd_type         cmd
);

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_FLUSH_SWAP = 3'd1;
   localparam logic [2:0] S_FLUSH_END  = 3'd2;
   localparam logic [2:0] S_FLUSH_RES  = 3'd3;
   localparam logic [2:0] S_EMIT_ONE   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       eoi_ff, eoi_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Sequencing of the results caused by one transaction.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      eoi_in   = eoi_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.insert = 1'b1;
               eoi_in     = req_end_of_input;
               if (status.ins_flush) begin
                  state_in = S_FLUSH_SWAP;
               end else if (req_end_of_input) begin
                  state_in = S_FLUSH_END;
               end else if (status.ins_full) begin
                  state_in = S_EMIT_ONE;
               end
            end
         end
         S_FLUSH_SWAP: begin
            // The reservoir is full: close the run, then swap roles.
            if (!status.any_valid) begin
               cmd.swap = 1'b1;
               state_in = eoi_ff ? S_FLUSH_END : S_EMIT_ONE;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.one_valid) begin
                  cmd.run_end = 1'b1;
                  cmd.swap    = 1'b1;
                  state_in    = eoi_ff ? S_FLUSH_END : S_EMIT_ONE;
               end
            end
         end
         S_FLUSH_END: begin
            // End of input: drain memory as the end of the current run.
            if (!status.any_valid) begin
               if (status.res_nonempty) begin
                  cmd.swap = 1'b1;
                  state_in = S_FLUSH_RES;
               end else begin
                  cmd.restart = 1'b1;
                  state_in    = S_IDLE;
               end
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.one_valid) begin
                  cmd.run_end = 1'b1;
                  if (status.res_nonempty) begin
                     cmd.swap = 1'b1;
                     state_in = S_FLUSH_RES;
                  end else begin
                     cmd.burst_last = 1'b1;
                     cmd.restart    = 1'b1;
                     state_in       = S_IDLE;
                  end
               end
            end
         end
         S_FLUSH_RES: begin
            // End of input: drain the former reservoir as a run of its own.
            if (!status.any_valid) begin
               cmd.restart = 1'b1;
               state_in    = S_IDLE;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.one_valid) begin
                  cmd.run_end    = 1'b1;
                  cmd.burst_last = 1'b1;
                  cmd.restart    = 1'b1;
                  state_in       = S_IDLE;
               end
            end
         end
         S_EMIT_ONE: begin
            // Regular step: emit the minimum and free its slot.
            if (!status.any_valid) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.set_free   = 1'b1;
               cmd.burst_last = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         eoi_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         eoi_ff   <= eoi_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/natural_selection_run_generator.sv]
// A transaction that emits one record waits in S_EMIT_ONE for a free output
// register, then loads it. The controller accepts the next record only once
// that emission is made; a flush emits one record per cycle from the minimum
// tree while the output register is free, up to 2*MEMORY_ENTRIES-1 results.
// Reset: synchronous; clears control state and counters, no clearing pass.
// ----------------------------------------------------------------------------
// natural_selection_run_generator: run generator for external sorting
// Natural selection with a memory and a reservoir of MEMORY_ENTRIES records;
// emits sorted runs with run numbers, run end and transaction end marks.
// ----------------------------------------------------------------------------
`default_nettype none

module natural_selection_run_generator #(
   parameter int MEMORY_ENTRIES = nsrg_pkg::MEMORY_ENTRIES_DEF,
   parameter int KEY_BITS       = nsrg_pkg::KEY_BITS_DEF
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire logic signed [nsrg_pkg::REC_BITS-1:0] req_record_value,
   input  wire                                       req_end_of_input,
   input  wire                                       req_valid,
   output logic                                      req_ready,
   output logic signed [nsrg_pkg::REC_BITS-1:0]      rsp_out_value,
   output logic [nsrg_pkg::RUN_BITS-1:0]             rsp_run_index,
   output logic                                      rsp_run_end,
   output logic                                      rsp_burst_last,
   output logic                                      rsp_valid,
   input  wire                                       rsp_ready
);

   nsrg_pkg::dp_cmd_type    cmd;
   nsrg_pkg::dp_status_type status;

   // Controller.
   nsrg_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_end_of_input (req_end_of_input),
      .req_ready        (req_ready),
      .status           (status),
      .cmd              (cmd)
   );

   // Datapath.
   nsrg_dp #(
      .MEMORY_ENTRIES (MEMORY_ENTRIES),
      .KEY_BITS       (KEY_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_record_value (req_record_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_out_value    (rsp_out_value),
      .rsp_run_index    (rsp_run_index),
      .rsp_run_end      (rsp_run_end),
      .rsp_burst_last   (rsp_burst_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready)
   );

endmodule

`default_nettype wire

[rtl/core/nsrg_checker.sv]
// ----------------------------------------------------------------------------
// nsrg_checker: port level assertions of the natural selection run generator
// Watches the handshakes and the transaction ordering seen at the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nsrg_checker (
   input wire clock,
   input wire reset,
   input wire req_valid,
   input wire req_ready,
   input wire req_end_of_input,
   input wire rsp_valid,
   input wire rsp_ready,
   input wire rsp_burst_last
);

   // A pending result stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   // Reset leaves no result on offer.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // The final record of the input always causes a drain.
   a_eoi_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_end_of_input) |=> !req_ready)
      else $error("end of input accepted without a drain");

   // No new transaction while the results of the last one are unfinished.
   a_burst_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_burst_last) |-> !req_ready)
      else $error("input accepted in the middle of a burst");

endmodule

bind natural_selection_run_generator nsrg_checker u_nsrg_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_end_of_input (req_end_of_input),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_burst_last   (rsp_burst_last)
);

`default_nettype wire

[test/tb_natural_selection_run_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_natural_selection_run_generator: self-checking bench for the run generator
// Sends signed records with end-of-input marks over the request channel. A
// predictor of the memory, the reservoir and the run counter works out each
// record's results, and every result transaction is checked in order. The
// opening table covers extremes, ties, the reservoir flush and the longest
// drain. Random sequences with random gaps and stalls follow, including one
// long receiver hold-off.
// ----------------------------------------------------------------------------

module tb_natural_selection_run_generator;

   localparam int ENTRIES       = nsrg_pkg::MEMORY_ENTRIES_DEF;
   localparam int RANDOM_ITEMS  = 198;
   localparam int CALM_ITEMS    = 30;
   localparam int HOLD_CYCLES   = 80;
   localparam int DRAIN_CYCLES  = 40;
   localparam int NUM_DIRECTED  = 22;
   localparam longint TIMEOUT_NS = 2_000_000;

   localparam logic signed [nsrg_pkg::REC_BITS-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [nsrg_pkg::REC_BITS-1:0] KEY_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic signed [nsrg_pkg::REC_BITS-1:0] value;
      logic [nsrg_pkg::RUN_BITS-1:0]        run;
      logic                                 run_end;
      logic                                 burst_last;
   } run_record_type;

   typedef struct packed {
      logic signed [nsrg_pkg::REC_BITS-1:0] value;
      logic                                 eoi;
      logic                                 typed;
      run_record_type                       want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic signed [nsrg_pkg::REC_BITS-1:0] req_record_value = '0;
   logic                                 req_end_of_input = 1'b0;
   logic                                 req_valid        = 1'b0;
   logic                                 req_ready;
   logic signed [nsrg_pkg::REC_BITS-1:0] rsp_out_value;
   logic [nsrg_pkg::RUN_BITS-1:0]        rsp_run_index;
   logic                                 rsp_run_end;
   logic                                 rsp_burst_last;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;

   // Predictor state: selection memory, reservoir and run counter.
   logic signed [nsrg_pkg::REC_BITS-1:0] sel_key [ENTRIES];
   logic                                 sel_valid [ENTRIES];
   logic signed [nsrg_pkg::REC_BITS-1:0] hold_key [ENTRIES];
   int                                   hold_count;
   int                                   fill_count;
   int                                   open_slot;
   logic signed [nsrg_pkg::REC_BITS-1:0] floor_key;
   logic [nsrg_pkg::RUN_BITS-1:0]        run_number;

   run_record_type burst_records [$];
   run_record_type due_records [$];
   stim_row_type   directed_rows [NUM_DIRECTED];

   int mismatch_count = 0;
   bit calm           = 1'b0;
   bit hold_request   = 1'b0;

   natural_selection_run_generator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_record_value (req_record_value),
      .req_end_of_input (req_end_of_input),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .rsp_out_value    (rsp_out_value),
      .rsp_run_index    (rsp_run_index),
      .rsp_run_end      (rsp_run_end),
      .rsp_burst_last   (rsp_burst_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready)
   );

   // Clock with a period of 8 ns.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Return the selection state to its empty form; the run counter carries on.
   task automatic restart_selection();
      for (int i = 0; i < ENTRIES; i++) begin
         sel_valid[i] = 1'b0;
         sel_key[i]   = '0;
         hold_key[i]  = '0;
      end
      hold_count = 0;
      fill_count = 0;
      open_slot  = 0;
      floor_key  = '0;
   endtask

   // Emit the smallest valid memory entry, lowest slot on a tie.
   // Returns ENTRIES when memory is empty.
   function automatic int pop_smallest();
      int best;
      run_record_type rec;
      best = ENTRIES;
      for (int i = 0; i < ENTRIES; i++) begin
         if (sel_valid[i] && (best == ENTRIES || sel_key[i] < sel_key[best])) begin
            best = i;
         end
      end
      if (best < ENTRIES) begin
         rec = '{sel_key[best], run_number, 1'b0, 1'b0};
         burst_records.push_back(rec);
         floor_key       = sel_key[best];
         sel_valid[best] = 1'b0;
      end
      return best;
   endfunction

   // Empty memory in sorted order and close the run if anything came out.
   task automatic flush_memory();
      int start;
      int idx;
      start = burst_records.size();
      do begin
         idx = pop_smallest();
      end while (idx < ENTRIES);
      if (burst_records.size() > start) begin
         burst_records[burst_records.size()-1].run_end = 1'b1;
         run_number = run_number + 1'b1;
      end
   endtask

   // The reservoir becomes memory, in arrival order.
   task automatic promote_reservoir();
      for (int i = 0; i < ENTRIES; i++) begin
         sel_key[i]   = hold_key[i];
         sel_valid[i] = (i < hold_count);
      end
      hold_count = 0;
   endtask

   // Work out the results of one accepted record into burst_records.
   task automatic take_record(input logic signed [nsrg_pkg::REC_BITS-1:0] value,
                              input logic eoi);
      bit full;
      int idx;
      full = 1'b0;
      burst_records.delete();
      if (fill_count < ENTRIES) begin
         sel_key[fill_count]   = value;
         sel_valid[fill_count] = 1'b1;
         fill_count++;
         full = (fill_count == ENTRIES);
      end else if (value >= floor_key) begin
         sel_key[open_slot]   = value;
         sel_valid[open_slot] = 1'b1;
         full = 1'b1;
      end else begin
         if (hold_count < ENTRIES) begin
            hold_key[hold_count] = value;
            hold_count++;
         end
         if (hold_count >= ENTRIES) begin
            flush_memory();
            promote_reservoir();
            full = 1'b1;
         end
      end
      if (eoi) begin
         flush_memory();
         if (hold_count > 0) begin
            promote_reservoir();
            flush_memory();
         end
         restart_selection();
      end else if (full) begin
         idx = pop_smallest();
         open_slot = (idx < ENTRIES) ? idx : 0;
      end
      if (burst_records.size() > 0) begin
         burst_records[burst_records.size()-1].burst_last = 1'b1;
      end
   endtask

   // Offer one record and hold it until the request transaction completes.
   task automatic offer_record(input logic signed [nsrg_pkg::REC_BITS-1:0] value,
                               input logic eoi);
      req_record_value <= value;
      req_end_of_input <= eoi;
      req_valid        <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   // Between transactions the sender sometimes idles for a short burst.
   task automatic sender_gap();
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid        <= 1'b0;
         req_record_value <= $urandom;
         req_end_of_input <= 1'($urandom_range(0, 1));
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic signed [nsrg_pkg::REC_BITS-1:0] pick_extreme();
      case ($urandom_range(0, 6))
         0: return KEY_MIN;
         1: return KEY_MAX;
         2: return KEY_MIN + 1;
         3: return KEY_MAX - 1;
         4: return '0;
         5: return -1;
         default: return $urandom;
      endcase
   endfunction

   // Stimulus: reset, the opening table, then random sequences.
   initial begin
      int remaining;
      int seq_len;
      int mode;
      int trend;
      logic signed [nsrg_pkg::REC_BITS-1:0] value;
      logic eoi;

      directed_rows = '{
         // Single records closed at once: each is its own run.
         '{KEY_MIN, 1'b1, 1'b1, '{KEY_MIN, 16'd0, 1'b1, 1'b1}},
         '{KEY_MAX, 1'b1, 1'b1, '{KEY_MAX, 16'd1, 1'b1, 1'b1}},
         '{32'sd0,  1'b1, 1'b1, '{32'sd0,  16'd2, 1'b1, 1'b1}},
         '{-32'sd1, 1'b1, 1'b1, '{-32'sd1, 16'd3, 1'b1, 1'b1}},
         // Fill memory with ties and extremes; the last one emits the minimum.
         '{32'sd5,  1'b0, 1'b0, '0},
         '{-32'sd3, 1'b0, 1'b0, '0},
         '{32'sd5,  1'b0, 1'b0, '0},
         '{KEY_MAX, 1'b0, 1'b0, '0},
         '{KEY_MIN, 1'b0, 1'b0, '0},
         '{32'sd7,  1'b0, 1'b0, '0},
         '{32'sd0,  1'b0, 1'b0, '0},
         '{-32'sd3, 1'b0, 1'b0, '0},
         // Steady state, then a record equal to the last emitted key.
         '{32'sd10, 1'b0, 1'b0, '0},
         '{-32'sd3, 1'b0, 1'b0, '0},
         // Smaller records go to the reservoir, with a tie among them.
         '{-32'sd100,  1'b0, 1'b0, '0},
         '{-32'sd200,  1'b0, 1'b0, '0},
         '{KEY_MIN,    1'b0, 1'b0, '0},
         '{-32'sd5,    1'b0, 1'b0, '0},
         '{-32'sd5,    1'b0, 1'b0, '0},
         '{-32'sd1000, 1'b0, 1'b0, '0},
         // Reservoir fills on the final record: flush, swap and full drain.
         '{-32'sd7, 1'b0, 1'b0, '0},
         '{-32'sd8, 1'b1, 1'b0, '0}
      };

      restart_selection();
      run_number = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Opening table.
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         offer_record(directed_rows[i].value, directed_rows[i].eoi);
         take_record(directed_rows[i].value, directed_rows[i].eoi);
         if (directed_rows[i].typed) begin
            due_records.push_back(directed_rows[i].want);
         end else begin
            foreach (burst_records[k]) due_records.push_back(burst_records[k]);
         end
         sender_gap();
      end

      // Random sequences, each closed by an end-of-input record.
      hold_request = 1'b1;
      remaining    = RANDOM_ITEMS;
      while (remaining > 0) begin
         mode    = $urandom_range(0, 4);
         seq_len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) :
                                                 $urandom_range(8, 40);
         if (seq_len > remaining) seq_len = remaining;
         trend = $urandom_range(0, 2000) - 1000;
         for (int j = 0; j < seq_len; j++) begin
            case (mode)
               0: value = $urandom;
               1: value = $urandom_range(0, 40) - 20;
               2: begin
                  trend = trend - $urandom_range(0, 64);
                  value = trend + $urandom_range(0, 20) - 10;
               end
               3: value = pick_extreme();
               default: value = $urandom_range(0, 1000) - 500;
            endcase
            eoi = (j == seq_len - 1);
            offer_record(value, eoi);
            take_record(value, eoi);
            foreach (burst_records[k]) due_records.push_back(burst_records[k]);
            remaining--;
            if (remaining <= CALM_ITEMS) calm = 1'b1;
            sender_gap();
         end
      end
      req_valid <= 1'b0;

      // Wait for the remaining results, then a little longer.
      while (due_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_natural_selection_run_generator: done, clean");
      end else begin
         $display("tb_natural_selection_run_generator: done, errors");
      end
      $finish;
   end

   // Receiver: random stall bursts, one long hold-off, and result checking.
   initial begin
      int stall_left;
      bit hold_done;
      run_record_type want;
      stall_left = 0;
      hold_done  = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            // Hold off long enough for the block to fill and stall its input.
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (calm) begin
               rsp_ready <= 1'b1;
            end else if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
               stall_left = $urandom_range(1, 4) - 1;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
            @(posedge clock);
            if (rsp_valid && rsp_ready) begin
               if (due_records.size() == 0) begin
                  $error("unexpected result transaction: out_value %0d", rsp_out_value);
                  mismatch_count++;
               end else begin
                  want = due_records.pop_front();
                  if (rsp_out_value !== want.value) begin
                     $error("out_value: expected %0d, actual %0d", want.value, rsp_out_value);
                     mismatch_count++;
                  end
                  if (rsp_run_index !== want.run) begin
                     $error("run_index: expected %0d, actual %0d", want.run, rsp_run_index);
                     mismatch_count++;
                  end
                  if (rsp_run_end !== want.run_end) begin
                     $error("run_end: expected %0d, actual %0d", want.run_end, rsp_run_end);
                     mismatch_count++;
                  end
                  if (rsp_burst_last !== want.burst_last) begin
                     $error("burst_last: expected %0d, actual %0d",
                            want.burst_last, rsp_burst_last);
                     mismatch_count++;
                  end
               end
            end
         end
      end
   end

   // Watchdog for a hung run.
   initial begin
      #(TIMEOUT_NS);
      $display("tb_natural_selection_run_generator: done, errors");
      $finish;
   end

endmodule
